[rtl/cdq_pkg.sv]
// Shared types and constants for the circular deque block.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps

package cdq_pkg;

  localparam int DATA_W        = 32;
  localparam int CMD_W         = 2;
  localparam int STAT_W        = 2;
  localparam int OCC_W         = 4;
  localparam int DEPTH_DEFAULT = 8;

  // Commands carried by an input transaction
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_POP_BACK   = 2'd2,
    CMD_POP_FRONT  = 2'd3
  } cmd_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // Outcome of one command, from the pointer unit to the top level
  typedef struct packed {
    status_e            status;
    logic [OCC_W-1:0]   occupancy;
    logic               pop_ok;
    logic               wr_en;
    logic               rd_en;
  } ptr_res_t;

endpackage

[rtl/circular_deque_top.sv]
// Top level of the circular deque: stream handshake, result pipeline and
// output register. Depends on cdq_pkg, cdq_ram and cdq_ptr.
//
//   Channel  Dir  tdata (low bit up)                     tuser
//   s        in   push_value[31:0]                       cmd[1:0]
//   m        out  popped_value[31:0], occupancy[35:32]   status[1:0]
//
// A command is decided and its slot written or read at the edge that accepts
// it; the result waits in the pending stage until the output register is free,
// by then the slot memory has its read data out. One command per cycle is
// taken while the output side keeps up. A stalled output holds the result
// and the one behind it, then stops accepting. Reset leaves the deque empty;
// slot contents are not cleared and are only read after being written.
`timescale 1ns / 1ps

module circular_deque_top #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  logic signed [31:0] s_tdata_i,  // [31:0] push_value
  input  logic [1:0]         s_tuser_i,  // [1:0] cmd
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  output logic [39:0]        m_tdata_o,  // [31:0] popped_value, [35:32] occupancy, rest 0
  output logic [1:0]         m_tuser_o   // [1:0] status
);

  localparam int IDX_W = $clog2(DEPTH);

  logic                       step;
  logic [IDX_W-1:0]           addr;
  cdq_pkg::ptr_res_t          res;
  logic [cdq_pkg::DATA_W-1:0] rdata;

  logic                       p_valid_q;
  cdq_pkg::status_e           p_status_q;
  logic [cdq_pkg::OCC_W-1:0]  p_occ_q;
  logic                       p_pop_q;
  logic                       p_move;

  logic                       out_valid_q;
  cdq_pkg::status_e           out_status_q;
  logic [cdq_pkg::DATA_W-1:0] out_value_q;
  logic [cdq_pkg::OCC_W-1:0]  out_occ_q;

  // Pointer unit decides each accepted command
  cdq_ptr #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_ptr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cmd_i  (cdq_pkg::cmd_e'(s_tuser_i)),
    .addr_o (addr),
    .res_o  (res)
  );

  // Slot memory
  cdq_ram #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (res.wr_en),
    .re_i    (res.rd_en),
    .addr_i  (addr),
    .wdata_i (s_tdata_i),
    .rdata_o (rdata)
  );

  // Advance the pending stage when the output register frees up
  assign p_move     = p_valid_q && (!out_valid_q || m_tready_i);
  assign s_tready_o = !p_valid_q || p_move;
  assign step       = s_tvalid_i && s_tready_o;

  // Hold the decision while the slot read completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (s_tready_o) begin
      p_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      p_status_q <= res.status;
      p_occ_q    <= res.occupancy;
      p_pop_q    <= res.pop_ok;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (p_move) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_move) begin
      out_status_q <= p_status_q;
      out_value_q  <= p_pop_q ? rdata : '0;
      out_occ_q    <= p_occ_q;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {4'b0, out_occ_q, out_value_q};
  assign m_tuser_o  = out_status_q;

endmodule

[rtl/cdq_ram.sv]
// Slot store of the deque: one write/read port, registered read data.
// Depends on cdq_pkg for the data width.
`timescale 1ns / 1ps

module cdq_ram #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic                       re_i,
  input  logic [IDX_W-1:0]           addr_i,
  input  logic [cdq_pkg::DATA_W-1:0] wdata_i,
  output logic [cdq_pkg::DATA_W-1:0] rdata_o
);

  logic [cdq_pkg::DATA_W-1:0] mem [DEPTH];
  logic [cdq_pkg::DATA_W-1:0] rdata_q;

  // Write the addressed slot
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // Read the addressed slot; the read data is registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/cdq_ptr.sv]
// Head/tail pointer unit: decides each command, updates the ring indices
// and drives the slot address. Depends on cdq_pkg.
`timescale 1ns / 1ps

module cdq_ptr #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  cdq_pkg::cmd_e     cmd_i,
  output logic [IDX_W-1:0]  addr_o,
  output cdq_pkg::ptr_res_t res_o
);

  localparam int               CNT_W    = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] tail_q, tail_d;
  logic             empty_q, empty_d;
  logic             full;
  logic [CNT_W-1:0] cnt_next;
  logic [CNT_W+cdq_pkg::OCC_W-1:0] cnt_ext;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? LAST_IDX : i - IDX_W'(1);
  endfunction

  // Element count from the indices: ((t - h) mod DEPTH) + 1, zero when empty
  function automatic logic [CNT_W-1:0] count_of(input logic [IDX_W-1:0] h,
                                                input logic [IDX_W-1:0] t,
                                                input logic             e);
    logic [IDX_W:0] diff;
    diff = {1'b0, t} - {1'b0, h};
    if (diff[IDX_W]) begin
      diff = diff + (IDX_W+1)'(DEPTH);
    end
    return e ? '0 : CNT_W'(diff[IDX_W-1:0]) + CNT_W'(1);
  endfunction

  assign full = !empty_q && (ring_next(tail_q) == head_q);

  // Decide the command against the current indices
  always_comb begin
    head_d          = head_q;
    tail_d          = tail_q;
    empty_d         = empty_q;
    addr_o          = '0;
    res_o.status    = cdq_pkg::ST_OK;
    res_o.pop_ok    = 1'b0;
    res_o.wr_en     = 1'b0;
    res_o.rd_en     = 1'b0;
    case (cmd_i)
      cdq_pkg::CMD_PUSH_BACK, cdq_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          res_o.status = cdq_pkg::ST_OVERFLOW;
        end else if (empty_q) begin
          head_d      = '0;
          tail_d      = '0;
          empty_d     = 1'b0;
          addr_o      = '0;
          res_o.wr_en = step_i;
        end else if (cmd_i == cdq_pkg::CMD_PUSH_BACK) begin
          tail_d      = ring_next(tail_q);
          addr_o      = ring_next(tail_q);
          res_o.wr_en = step_i;
        end else begin
          head_d      = ring_prev(head_q);
          addr_o      = ring_prev(head_q);
          res_o.wr_en = step_i;
        end
      end
      cdq_pkg::CMD_POP_BACK, cdq_pkg::CMD_POP_FRONT: begin
        if (empty_q) begin
          res_o.status = cdq_pkg::ST_UNDERFLOW;
        end else if (head_q == tail_q) begin
          // Last element leaves: back to the empty ring at slot zero
          addr_o       = head_q;
          res_o.rd_en  = step_i;
          res_o.pop_ok = 1'b1;
          empty_d      = 1'b1;
          head_d       = '0;
          tail_d       = '0;
        end else if (cmd_i == cdq_pkg::CMD_POP_BACK) begin
          addr_o       = tail_q;
          res_o.rd_en  = step_i;
          res_o.pop_ok = 1'b1;
          tail_d       = ring_prev(tail_q);
        end else begin
          addr_o       = head_q;
          res_o.rd_en  = step_i;
          res_o.pop_ok = 1'b1;
          head_d       = ring_next(head_q);
        end
      end
      default: begin
        res_o.status = cdq_pkg::ST_OK;
      end
    endcase

    // Report the count after the command, masked to the field width
    cnt_next        = count_of(head_d, tail_d, empty_d);
    cnt_ext         = {{cdq_pkg::OCC_W{1'b0}}, cnt_next};
    res_o.occupancy = cnt_ext[cdq_pkg::OCC_W-1:0];
  end

  // Commit the indices on an accepted command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
    end else if (step_i) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
    end
  end

endmodule

[dv/circular_deque_top_tb.sv]
// Self-checking testbench for circular_deque_top: a directed table of deque
// commands, then biased random fill/drain traffic, checked by a local predictor.
// Depends on cdq_pkg and the circular deque RTL.
`timescale 1ns / 1ps

module circular_deque_top_tb;

  localparam int RING        = cdq_pkg::DEPTH_DEFAULT;
  localparam int RANDOM_CMDS = 1350;
  localparam int HOLD_CYCLES = 80;

  // Expected outcome of one command
  typedef struct packed {
    cdq_pkg::status_e          status;
    logic [31:0]               popped;
    logic [cdq_pkg::OCC_W-1:0] occ;
  } deque_result_t;

  // One row of the directed table; typed rows carry their own expectation
  typedef struct packed {
    cdq_pkg::cmd_e             cmd;
    logic [31:0]               value;
    logic                      typed;
    cdq_pkg::status_e          status;
    logic [31:0]               popped;
    logic [cdq_pkg::OCC_W-1:0] occ;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_tvalid_i;
  logic               s_tready_o;
  logic signed [31:0] s_tdata_i;
  logic [1:0]         s_tuser_i;
  logic               m_tvalid_o;
  logic               m_tready_i;
  logic [39:0]        m_tdata_o;
  logic [1:0]         m_tuser_o;

  // Predictor state
  logic [31:0]   ring_words [RING];
  int unsigned   front_ix;
  int unsigned   back_ix;
  bit            ring_empty;
  deque_result_t expected_results[$];
  deque_result_t head_exp;

  int error_count;
  bit src_gaps_on;
  bit sink_gaps_on;
  bit hold_req;
  bit hold_done;

  // Underflow, then fill to full from both ends, hit overflow, drain past empty
  stim_row_t directed_rows [26] = '{
    '{cdq_pkg::CMD_POP_BACK,   32'h0000_0000, 1'b1, cdq_pkg::ST_UNDERFLOW, 32'h0, 4'd0},
    '{cdq_pkg::CMD_POP_FRONT,  32'hdead_beef, 1'b1, cdq_pkg::ST_UNDERFLOW, 32'h0, 4'd0},
    '{cdq_pkg::CMD_PUSH_BACK,  32'h7fff_ffff, 1'b1, cdq_pkg::ST_OK,        32'h0, 4'd1},
    '{cdq_pkg::CMD_POP_BACK,   32'h0000_0000, 1'b0, cdq_pkg::ST_OK,        32'h0, 4'd0},
    '{cdq_pkg::CMD_PUSH_FRONT, 32'h8000_0000, 1'b1, cdq_pkg::ST_OK,        32'h0, 4'd1},
    '{cdq_pkg::CMD_POP_FRONT,  32'hffff_ffff, 1'b0, cdq_pkg::ST_OK,        32'h0, 4'd0},
    '{cdq_pkg::CMD_POP_FRONT,  32'h0000_0000, 1'b1, cdq_pkg::ST_UNDERFLOW, 32'h0, 4'd0},
    '{cdq_pkg::CMD_PUSH_BACK,  32'h7fff_ffff, 1'b1, cdq_pkg::ST_OK,        32'h0, 4'd1},
    '{cdq_pkg::CMD_PUSH_FRONT, 32'h8000_0000, 1'b1, cdq_pkg::ST_OK,        32'h0, 4'd2},
    '{cdq_pkg::CMD_PUSH_BACK,  32'hffff_ffff, 1'b1, cdq_pkg::ST_OK,        32'h0, 4'd3},
    '{cdq_pkg::CMD_PUSH_FRONT, 32'h0000_0000, 1'b1, cdq_pkg::ST_OK,        32'h0, 4'd4},
    '{cdq_pkg::CMD_PUSH_BACK,  32'h0000_0001, 1'b1, cdq_pkg::ST_OK,        32'h0, 4'd5},
    '{cdq_pkg::CMD_PUSH_FRONT, 32'h5555_5555, 1'b1, cdq_pkg::ST_OK,        32'h0, 4'd6},
    '{cdq_pkg::CMD_PUSH_BACK,  32'haaaa_aaaa, 1'b1, cdq_pkg::ST_OK,        32'h0, 4'd7},
    '{cdq_pkg::CMD_PUSH_FRONT, 32'hffff_fffe, 1'b1, cdq_pkg::ST_OK,        32'h0, 4'd8},
    '{cdq_pkg::CMD_PUSH_BACK,  32'h1234_5678, 1'b1, cdq_pkg::ST_OVERFLOW,  32'h0, 4'd8},
    '{cdq_pkg::CMD_PUSH_FRONT, 32'h8765_4321, 1'b1, cdq_pkg::ST_OVERFLOW,  32'h0, 4'd8},
    '{cdq_pkg::CMD_POP_FRONT,  32'h0000_0000, 1'b0, cdq_pkg::ST_OK,        32'h0, 4'd0},
    '{cdq_pkg::CMD_POP_BACK,   32'hffff_ffff, 1'b0, cdq_pkg::ST_OK,        32'h0, 4'd0},
    '{cdq_pkg::CMD_POP_BACK,   32'h0000_0000, 1'b0, cdq_pkg::ST_OK,        32'h0, 4'd0},
    '{cdq_pkg::CMD_POP_FRONT,  32'h0000_0000, 1'b0, cdq_pkg::ST_OK,        32'h0, 4'd0},
    '{cdq_pkg::CMD_POP_BACK,   32'h0000_0000, 1'b0, cdq_pkg::ST_OK,        32'h0, 4'd0},
    '{cdq_pkg::CMD_POP_FRONT,  32'h0000_0000, 1'b0, cdq_pkg::ST_OK,        32'h0, 4'd0},
    '{cdq_pkg::CMD_POP_BACK,   32'h0000_0000, 1'b0, cdq_pkg::ST_OK,        32'h0, 4'd0},
    '{cdq_pkg::CMD_POP_FRONT,  32'h0000_0000, 1'b0, cdq_pkg::ST_OK,        32'h0, 4'd0},
    '{cdq_pkg::CMD_POP_BACK,   32'h0000_0000, 1'b1, cdq_pkg::ST_UNDERFLOW, 32'h0, 4'd0}
  };

  circular_deque_top #(
    .DEPTH(RING)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata_i),
    .s_tuser_i (s_tuser_i),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o),
    .m_tuser_o (m_tuser_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard limit on the run
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned occupancy_now();
    if (ring_empty) return 0;
    return ((back_ix + RING - front_ix) % RING) + 1;
  endfunction

  // Apply one command to the predicted deque and return its outcome
  function automatic deque_result_t step_deque(cdq_pkg::cmd_e c, logic [31:0] v);
    deque_result_t r;
    r.status = cdq_pkg::ST_OK;
    r.popped = '0;
    if (c == cdq_pkg::CMD_PUSH_BACK || c == cdq_pkg::CMD_PUSH_FRONT) begin
      if (occupancy_now() >= RING) begin
        r.status = cdq_pkg::ST_OVERFLOW;
      end else if (ring_empty) begin
        front_ix      = 0;
        back_ix       = 0;
        ring_words[0] = v;
        ring_empty    = 1'b0;
      end else if (c == cdq_pkg::CMD_PUSH_BACK) begin
        back_ix             = (back_ix + 1) % RING;
        ring_words[back_ix] = v;
      end else begin
        front_ix             = (front_ix + RING - 1) % RING;
        ring_words[front_ix] = v;
      end
    end else begin
      if (ring_empty) begin
        r.status = cdq_pkg::ST_UNDERFLOW;
      end else if (front_ix == back_ix) begin
        // last element leaves, both ends return to slot 0
        r.popped   = ring_words[front_ix];
        ring_empty = 1'b1;
        front_ix   = 0;
        back_ix    = 0;
      end else if (c == cdq_pkg::CMD_POP_BACK) begin
        r.popped = ring_words[back_ix];
        back_ix  = (back_ix + RING - 1) % RING;
      end else begin
        r.popped = ring_words[front_ix];
        front_ix = (front_ix + 1) % RING;
      end
    end
    r.occ = cdq_pkg::OCC_W'(occupancy_now());
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
    $display("MISMATCH at %0t: %s got %0h want %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Offer one command, wait for its transaction, record what it should return
  task automatic send_cmd(input cdq_pkg::cmd_e c, input logic [31:0] v, input bit typed,
                          input deque_result_t want);
    deque_result_t pred;
    while (src_gaps_on && $urandom_range(99) < 7) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= c;
    s_tdata_i  <= v;
    do @(posedge clk_i); while (!s_tready_o);
    pred = step_deque(c, v);
    expected_results.insert(expected_results.size(), typed ? want : pred);
  endtask

  // Result sink: random stalls, plus one long hold-off on request
  initial begin
    m_tready_i = 1'b0;
    hold_done  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        m_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        m_tready_i <= !(sink_gaps_on && $urandom_range(99) < 7);
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", {m_tuser_o, m_tdata_o[37:0]}, '0);
      end else begin
        head_exp = expected_results[0];
        expected_results.delete(0);
        if (m_tuser_o != head_exp.status)
          report_mismatch("status", 40'(m_tuser_o), 40'(head_exp.status));
        if (m_tdata_o[31:0] != head_exp.popped)
          report_mismatch("popped_value", 40'(m_tdata_o[31:0]), 40'(head_exp.popped));
        if (m_tdata_o[35:32] != head_exp.occ)
          report_mismatch("occupancy", 40'(m_tdata_o[35:32]), 40'(head_exp.occ));
        if (m_tdata_o[39:36] != '0)
          report_mismatch("tdata padding", 40'(m_tdata_o[39:36]), '0);
      end
    end
  end

  // Stimulus
  initial begin
    deque_result_t want;
    cdq_pkg::cmd_e c;
    logic [31:0]   v;
    int            mode;
    int            mode_left;
    int            push_pct;

    rst_ni       = 1'b0;
    s_tvalid_i   = 1'b0;
    s_tdata_i    = '0;
    s_tuser_i    = cdq_pkg::CMD_PUSH_BACK;
    error_count  = 0;
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
    hold_req     = 1'b0;
    front_ix     = 0;
    back_ix      = 0;
    ring_empty   = 1'b1;
    mode_left    = 0;
    mode         = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (directed_rows[i]) begin
      want.status = directed_rows[i].status;
      want.popped = directed_rows[i].popped;
      want.occ    = directed_rows[i].occ;
      send_cmd(directed_rows[i].cmd, directed_rows[i].value, directed_rows[i].typed, want);
    end

    // Random traffic in fill, drain and balanced phases
    want = '0;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      src_gaps_on  = !(n >= 300 && n < 600);
      sink_gaps_on = src_gaps_on;
      if (n == 800) hold_req = 1'b1;
      if (n == 1100) begin
        // pause until every outstanding result has come back
        s_tvalid_i <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk_i);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(2);
        mode_left = $urandom_range(40, 12);
      end
      mode_left--;
      push_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
      if ($urandom_range(99) < push_pct)
        c = $urandom_range(1) ? cdq_pkg::CMD_PUSH_FRONT : cdq_pkg::CMD_PUSH_BACK;
      else
        c = $urandom_range(1) ? cdq_pkg::CMD_POP_FRONT : cdq_pkg::CMD_POP_BACK;
      case ($urandom_range(15))
        0:       v = 32'h8000_0000;
        1:       v = 32'h7fff_ffff;
        2:       v = 32'hffff_ffff;
        3:       v = 32'h0000_0000;
        default: v = $urandom();
      endcase
      send_cmd(c, v, 1'b0, want);
    end

    // Drain, let the pipeline settle, then report
    s_tvalid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
